>>> rtl/cdf_pkg.sv
// shared types, codes and constants of the crater depth field
package cdf_pkg;

    // slot count default
    localparam int SLOTS_DEF = 8;

    // field widths
    localparam int OP_W      = 2;
    localparam int COORD_W   = 16;
    localparam int RAD_W     = 16;
    localparam int DEPTH_W   = 20;
    localparam int TIME_W    = 16;
    localparam int Y_W       = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // arithmetic unit widths
    localparam int DIV_DVD_W = 33;
    localparam int DIV_DVS_W = 16;
    localparam int SQRT_RAD_W = 50;
    localparam int SQRT_ROOT_W = SQRT_RAD_W / 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_IMPACT = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PUNCH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAL  = 2'd1;

    // register reset values
    localparam logic [TIME_W-1:0] PUNCH_RST = 16'd150;
    localparam logic [TIME_W-1:0] HEAL_RST  = 16'd7500;

    // one in q1.16
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // one crater slot
    typedef struct packed {
        logic               active;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] z;
        logic [RAD_W-1:0]   radius;
        logic [DEPTH_W-1:0] depth;
        logic [TIME_W-1:0]  age;
    } cdf_slot_t;

    // control shared by all cells of the ring
    typedef struct packed {
        logic              shift;
        logic              tick;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W:0]   life;
    } cdf_cell_ctl_t;

endpackage

>>> rtl/cdf_chan_if.sv
// handshake channels of the crater depth field: request, result, configuration
interface cdf_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [cdf_pkg::OP_W-1:0]             operation;
    logic signed [cdf_pkg::COORD_W-1:0]   pos_x;
    logic signed [cdf_pkg::COORD_W-1:0]   pos_z;
    logic [cdf_pkg::RAD_W-1:0]            radius;
    logic [cdf_pkg::DEPTH_W-1:0]          peak_depth;
    logic [cdf_pkg::TIME_W-1:0]           elapsed;
    logic signed [cdf_pkg::Y_W-1:0]       rest_y;
    logic signed [cdf_pkg::Y_W-1:0]       current_y;

    modport source (
        output valid, operation, pos_x, pos_z, radius, peak_depth, elapsed, rest_y, current_y,
        input  ready
    );
    modport sink (
        input  valid, operation, pos_x, pos_z, radius, peak_depth, elapsed, rest_y, current_y,
        output ready
    );
endinterface

interface cdf_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [cdf_pkg::DEPTH_W-1:0]    depth_sink;
    logic signed [cdf_pkg::Y_W-1:0] new_y;
    logic                           changed;

    modport source (output valid, depth_sink, new_y, changed, input ready);
    modport sink (input valid, depth_sink, new_y, changed, output ready);
endinterface

interface cdf_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [cdf_pkg::CFG_IDX_W-1:0]   index;
    logic [cdf_pkg::CFG_DAT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/cdf_cell.sv
// one crater slot cell of the rotating ring
module cdf_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cdf_pkg::cdf_cell_ctl_t ctl,
    input  logic                   load_en,
    input  cdf_pkg::cdf_slot_t     load_slot,
    input  cdf_pkg::cdf_slot_t     nbr_slot,
    output cdf_pkg::cdf_slot_t     slot
);
    cdf_pkg::cdf_slot_t slot_reg;
    cdf_pkg::cdf_slot_t slot_next;
    logic [cdf_pkg::TIME_W:0]   age_sum;
    logic [cdf_pkg::TIME_W-1:0] age_sat;

    // saturating age update
    assign age_sum = {1'b0, slot_reg.age} + {1'b0, ctl.elapsed};
    assign age_sat = age_sum[cdf_pkg::TIME_W] ? '1 : age_sum[cdf_pkg::TIME_W-1:0];

    // load, rotate or age
    always_comb
    begin
        slot_next = slot_reg;
        if (load_en)
        begin
            slot_next        = load_slot;
            slot_next.active = 1'b1;
            slot_next.age    = '0;
        end
        else if (ctl.shift)
        begin
            slot_next = nbr_slot;
        end
        else if (ctl.tick && slot_reg.active)
        begin
            slot_next.age    = age_sat;
            slot_next.active = ({1'b0, age_sat} <= ctl.life);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    assign slot = slot_reg;

endmodule

>>> rtl/cdf_div.sv
// restoring divider, one quotient bit per cycle
module cdf_div #(
    parameter int DVD_W = cdf_pkg::DIV_DVD_W,
    parameter int DVS_W = cdf_pkg::DIV_DVS_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic [DVD_W-1:0] quotient
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W:0]   trial;
    logic             fits;
    logic [DVS_W:0]   rem_new;

    // one trial subtraction
    assign trial   = {rem_reg, quo_reg[DVD_W-1]};
    assign fits    = (trial >= {1'b0, dvs_reg});
    assign rem_new = fits ? (trial - {1'b0, dvs_reg}) : trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(DVD_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            rem_reg <= rem_new[DVS_W-1:0];
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

>>> rtl/cdf_sqrt.sv
// bitwise integer square root, one result bit per cycle
module cdf_sqrt #(
    parameter int RAD_W = cdf_pkg::SQRT_RAD_W
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [RAD_W-1:0]   radicand,
    output logic               busy,
    output logic [RAD_W/2-1:0] root
);
    logic [RAD_W-1:0] v_reg;
    logic [RAD_W-1:0] r_reg;
    logic [RAD_W-1:0] b_reg;
    logic [RAD_W-1:0] rb;
    logic             take;

    assign rb   = r_reg + b_reg;
    assign take = (v_reg >= rb);

    // bit weight walks down two places per step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg <= '0;
        end
        else if (start)
        begin
            b_reg <= {2'b01, {(RAD_W-2){1'b0}}};
        end
        else
        begin
            b_reg <= b_reg >> 2;
        end
    end

    // remainder and root
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg <= radicand;
            r_reg <= '0;
        end
        else if (b_reg != '0)
        begin
            if (take)
            begin
                v_reg <= v_reg - rb;
                r_reg <= (r_reg >> 1) + b_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
        end
    end

    assign busy = (b_reg != '0);
    assign root = r_reg[RAD_W/2-1:0];

endmodule

>>> rtl/crater_depth_field_core.sv
// crater depth field: ring of slot cells with a shared sequential sink engine
//
// Channels: req takes one item (impact, tick or query), rsp gives one result
// item per request, cfg writes the punch duration (index 0) and the heal
// duration (index 1); cfg is always ready. Items are worked one at a time, in order.
// Impact: the ring rotates once past the head cell to find the lowest free
// slot or the oldest one, then that cell is loaded.
// Tick: every cell ages itself in parallel.
// Query: one rotation of the ring, one slot per step. An inactive slot, or
// one in its heal phase with a zero heal duration, is skipped without a divide.
// Any other slot starts with a divide for the time phase and the smoothstep;
// with zero depth now or zero radius it ends there. A live slot goes on to a
// square root for the distance and a divide for the ratio, plus smoothstep
// and multiply steps. The worst case is set by the shared divider and square root.
// Reset: all slots inactive, punch 150 ms, heal 7500 ms; the block is
// ready straight out of reset.
// Stall: a finished result waits in the output register; one further item
// is accepted and worked meanwhile, and its result holds until rsp frees.
module crater_depth_field_core #(
    parameter int SLOTS = cdf_pkg::SLOTS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    cdf_req_if.sink   req,
    cdf_rsp_if.source rsp,
    cdf_cfg_if.sink   cfg
);
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DVD_W = cdf_pkg::DIV_DVD_W;
    localparam int SQ_W  = cdf_pkg::SQRT_RAD_W;
    localparam int RT_W  = cdf_pkg::SQRT_ROOT_W;

    // engine states
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SCAN    = 4'd1;
    localparam logic [3:0] ST_LOAD    = 4'd2;
    localparam logic [3:0] ST_HEAD    = 4'd3;
    localparam logic [3:0] ST_DIVU    = 4'd4;
    localparam logic [3:0] ST_SSA     = 4'd5;
    localparam logic [3:0] ST_SSB     = 4'd6;
    localparam logic [3:0] ST_NOW     = 4'd7;
    localparam logic [3:0] ST_DX2     = 4'd8;
    localparam logic [3:0] ST_D2      = 4'd9;
    localparam logic [3:0] ST_SQRT    = 4'd10;
    localparam logic [3:0] ST_DIVR    = 4'd11;
    localparam logic [3:0] ST_CONTRIB = 4'd12;
    localparam logic [3:0] ST_NEXT    = 4'd13;
    localparam logic [3:0] ST_FIN     = 4'd14;
    localparam logic [3:0] ST_DONE    = 4'd15;

    logic [3:0] state_reg, state_next;

    // configuration
    logic [cdf_pkg::TIME_W-1:0] punch_reg, heal_reg;

    // latched item
    logic [cdf_pkg::OP_W-1:0]    op_reg, op_next;
    logic [cdf_pkg::COORD_W-1:0] x_reg, x_next, z_reg, z_next;
    logic [cdf_pkg::RAD_W-1:0]   rad_reg, rad_next;
    logic [cdf_pkg::DEPTH_W-1:0] dep_reg, dep_next;
    logic [cdf_pkg::Y_W-1:0]     rest_reg, rest_next, cur_reg, cur_next;

    // impact search
    logic [IDX_W-1:0]           k_reg, k_next;
    logic                       free_reg, free_next;
    logic [IDX_W-1:0]           free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]           old_idx_reg, old_idx_next;
    logic [cdf_pkg::TIME_W-1:0] old_age_reg, old_age_next;

    // query datapath
    logic                        heal_ph_reg, heal_ph_next;
    logic                        ss_sel_reg, ss_sel_next;
    logic [16:0]                 u_reg, u_next;
    logic [31:0]                 u2_reg, u2_next;
    logic [16:0]                 ss_reg, ss_next;
    logic [cdf_pkg::DEPTH_W-1:0] now_reg, now_next;
    logic signed [16:0]          dx_reg, dx_next, dz_reg, dz_next;
    logic [31:0]                 dxsq_reg, dxsq_next;
    logic [cdf_pkg::DEPTH_W-1:0] sink_reg, sink_next;
    logic [cdf_pkg::Y_W-1:0]     ny_reg, ny_next;
    logic                        chg_reg, chg_next;

    // result register
    logic                        rsp_valid_reg;
    logic [cdf_pkg::DEPTH_W-1:0] rsp_sink_reg;
    logic [cdf_pkg::Y_W-1:0]     rsp_y_reg;
    logic                        rsp_chg_reg;
    logic                        rsp_load;

    // ring
    cdf_pkg::cdf_slot_t     slots [SLOTS];
    cdf_pkg::cdf_slot_t     head;
    cdf_pkg::cdf_slot_t     load_slot;
    cdf_pkg::cdf_cell_ctl_t ctl;
    logic [SLOTS-1:0]       load_en;
    logic [IDX_W-1:0]       tgt_idx;
    logic                   shift;

    // arithmetic units
    logic                          div_start, div_busy;
    logic [DVD_W-1:0]              div_dvd, div_q;
    logic [cdf_pkg::DIV_DVS_W-1:0] div_dvs;
    logic [16:0]                   q_clamp;
    logic                          sq_start, sq_busy;
    logic [SQ_W-1:0]               sq_rad;
    logic [RT_W-1:0]               sq_root;

    // combinational helpers
    logic                        acc_req;
    logic signed [16:0]          dx_c, dz_c;
    logic [cdf_pkg::TIME_W-1:0]  heal_age;
    logic [17:0]                 ss_w;
    logic [49:0]                 ss_prod;
    logic [16:0]                 ss_val;
    logic [16:0]                 now_m;
    logic [36:0]                 now_prod;
    logic signed [33:0]          dxsq_full, dzsq_full;
    logic [32:0]                 d2_c;
    logic [36:0]                 c_prod;
    logic [cdf_pkg::DEPTH_W-1:0] c_val;
    logic signed [24:0]          v_c;
    logic signed [16:0]          q_c;
    logic signed [16:0]          qt_c;

    assign acc_req   = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign head      = slots[0];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            punch_reg <= cdf_pkg::PUNCH_RST;
            heal_reg  <= cdf_pkg::HEAL_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                cdf_pkg::CFG_PUNCH: punch_reg <= cfg.data;
                cdf_pkg::CFG_HEAL:  heal_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    // cell control
    assign shift       = (state_reg == ST_SCAN) || (state_reg == ST_NEXT);
    assign ctl.shift   = shift;
    assign ctl.tick    = acc_req && (req.operation == cdf_pkg::OP_TICK);
    assign ctl.elapsed = req.elapsed;
    assign ctl.life    = {1'b0, punch_reg} + {1'b0, heal_reg};

    assign tgt_idx          = free_reg ? free_idx_reg : old_idx_reg;
    assign load_slot.active = 1'b1;
    assign load_slot.x      = x_reg;
    assign load_slot.z      = z_reg;
    assign load_slot.radius = rad_reg;
    assign load_slot.depth  = dep_reg;
    assign load_slot.age    = '0;

    // ring of slot cells, each handing its slot to the one before it
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        localparam int NB = (i + 1) % SLOTS;
        assign load_en[i] = (state_reg == ST_LOAD) && (tgt_idx == IDX_W'(i));
        cdf_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .load_en   (load_en[i]),
            .load_slot (load_slot),
            .nbr_slot  (slots[NB]),
            .slot      (slots[i])
        );
    end

    cdf_div #(
        .DVD_W (DVD_W),
        .DVS_W (cdf_pkg::DIV_DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .quotient (div_q)
    );

    cdf_sqrt #(
        .RAD_W (SQ_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_rad),
        .busy     (sq_busy),
        .root     (sq_root)
    );

    // datapath pieces
    assign dx_c      = $signed({x_reg[15], x_reg}) - $signed({head.x[15], head.x});
    assign dz_c      = $signed({z_reg[15], z_reg}) - $signed({head.z[15], head.z});
    assign heal_age  = head.age - punch_reg;
    assign q_clamp   = (div_q > DVD_W'(cdf_pkg::ONE_Q16)) ? cdf_pkg::ONE_Q16 : div_q[16:0];
    assign ss_w      = 18'd196608 - {1'b0, u_reg[15:0], 1'b0};
    assign ss_prod   = {18'b0, u2_reg} * {32'b0, ss_w};
    assign ss_val    = (u_reg == '0) ? 17'd0 :
                       (u_reg[16] ? cdf_pkg::ONE_Q16 : {1'b0, ss_prod[47:32]});
    assign now_m     = heal_ph_reg ? (cdf_pkg::ONE_Q16 - ss_reg) : ss_reg;
    assign now_prod  = {17'b0, head.depth} * {20'b0, now_m};
    assign dxsq_full = dx_reg * dx_reg;
    assign dzsq_full = dz_reg * dz_reg;
    assign d2_c      = {1'b0, dxsq_reg} + {1'b0, dzsq_full[31:0]};
    assign c_prod    = {17'b0, now_reg} * {20'b0, (cdf_pkg::ONE_Q16 - ss_reg)};
    assign c_val     = c_prod[35:16];
    assign v_c       = $signed({rest_reg[15], rest_reg, 8'b0}) - $signed({5'b0, sink_reg});
    assign q_c       = v_c[24:8];
    assign qt_c      = q_c + $signed({16'b0, (v_c[24] && (v_c[7:0] != '0))});

    // divider and square root operands
    always_comb
    begin
        div_start = 1'b0;
        div_dvd   = {1'b0, sq_root, 7'b0} << 1;
        div_dvs   = head.radius;
        sq_start  = (state_reg == ST_D2);
        sq_rad    = {1'b0, d2_c, 16'b0};
        unique case (state_reg)
            ST_HEAD:
            begin
                if (head.active && (head.age < punch_reg))
                begin
                    div_start = 1'b1;
                    div_dvd   = {1'b0, head.age, 16'b0};
                    div_dvs   = punch_reg;
                end
                else if (head.active && (heal_reg != '0))
                begin
                    div_start = 1'b1;
                    div_dvd   = {1'b0, heal_age, 16'b0};
                    div_dvs   = heal_reg;
                end
            end
            ST_SQRT:
            begin
                div_start = !sq_busy;
                div_dvd   = {sq_root, 8'b0};
                div_dvs   = head.radius;
            end
            default: ;
        endcase
    end

    // engine sequencer
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        x_next        = x_reg;
        z_next        = z_reg;
        rad_next      = rad_reg;
        dep_next      = dep_reg;
        rest_next     = rest_reg;
        cur_next      = cur_reg;
        k_next        = k_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        old_idx_next  = old_idx_reg;
        old_age_next  = old_age_reg;
        heal_ph_next  = heal_ph_reg;
        ss_sel_next   = ss_sel_reg;
        u_next        = u_reg;
        u2_next       = u2_reg;
        ss_next       = ss_reg;
        now_next      = now_reg;
        dx_next       = dx_reg;
        dz_next       = dz_reg;
        dxsq_next     = dxsq_reg;
        sink_next     = sink_reg;
        ny_next       = ny_reg;
        chg_next      = chg_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc_req)
                begin
                    op_next   = req.operation;
                    x_next    = req.pos_x;
                    z_next    = req.pos_z;
                    rad_next  = req.radius;
                    dep_next  = req.peak_depth;
                    rest_next = req.rest_y;
                    cur_next  = req.current_y;
                    k_next    = '0;
                    free_next = 1'b0;
                    sink_next = '0;
                    case (req.operation)
                        cdf_pkg::OP_IMPACT: state_next = ST_SCAN;
                        cdf_pkg::OP_QUERY:  state_next = ST_HEAD;
                        default:            state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                // lowest free slot, else first of the oldest
                if (!head.active && !free_reg)
                begin
                    free_next     = 1'b1;
                    free_idx_next = k_reg;
                end
                if ((k_reg == '0) || (head.age > old_age_reg))
                begin
                    old_age_next = head.age;
                    old_idx_next = k_reg;
                end
                k_next = k_reg + 1'b1;
                if (k_reg == IDX_W'(SLOTS - 1))
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_DONE;
            end
            ST_HEAD:
            begin
                dx_next = dx_c;
                dz_next = dz_c;
                if (!head.active)
                begin
                    state_next = ST_NEXT;
                end
                else if (head.age < punch_reg)
                begin
                    heal_ph_next = 1'b0;
                    state_next   = ST_DIVU;
                end
                else if (heal_reg == '0)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    heal_ph_next = 1'b1;
                    state_next   = ST_DIVU;
                end
            end
            ST_DIVU:
            begin
                if (!div_busy)
                begin
                    u_next      = q_clamp;
                    ss_sel_next = 1'b0;
                    state_next  = ST_SSA;
                end
            end
            ST_SSA:
            begin
                u2_next    = u_reg[15:0] * u_reg[15:0];
                state_next = ST_SSB;
            end
            ST_SSB:
            begin
                ss_next    = ss_val;
                state_next = ss_sel_reg ? ST_CONTRIB : ST_NOW;
            end
            ST_NOW:
            begin
                now_next = now_prod[35:16];
                if ((now_prod[35:16] == '0) || (head.radius == '0))
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    state_next = ST_DX2;
                end
            end
            ST_DX2:
            begin
                dxsq_next  = dxsq_full[31:0];
                state_next = ST_D2;
            end
            ST_D2:
            begin
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (!sq_busy)
                begin
                    state_next = ST_DIVR;
                end
            end
            ST_DIVR:
            begin
                if (!div_busy)
                begin
                    u_next      = q_clamp;
                    ss_sel_next = 1'b1;
                    state_next  = ST_SSA;
                end
            end
            ST_CONTRIB:
            begin
                if (c_val > sink_reg)
                begin
                    sink_next = c_val;
                end
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                k_next = k_reg + 1'b1;
                if (k_reg == IDX_W'(SLOTS - 1))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_HEAD;
                end
            end
            ST_FIN:
            begin
                // truncate toward zero, saturate at the bottom
                if (qt_c < -17'sd32768)
                begin
                    ny_next = 16'h8000;
                end
                else
                begin
                    ny_next = qt_c[15:0];
                end
                chg_next   = (ny_next != cur_reg);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // engine payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        x_reg        <= x_next;
        z_reg        <= z_next;
        rad_reg      <= rad_next;
        dep_reg      <= dep_next;
        rest_reg     <= rest_next;
        cur_reg      <= cur_next;
        k_reg        <= k_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        old_idx_reg  <= old_idx_next;
        old_age_reg  <= old_age_next;
        heal_ph_reg  <= heal_ph_next;
        ss_sel_reg   <= ss_sel_next;
        u_reg        <= u_next;
        u2_reg       <= u2_next;
        ss_reg       <= ss_next;
        now_reg      <= now_next;
        dx_reg       <= dx_next;
        dz_reg       <= dz_next;
        dxsq_reg     <= dxsq_next;
        sink_reg     <= sink_next;
        ny_reg       <= ny_next;
        chg_reg      <= chg_next;
    end

    // output register
    assign rsp_load = (state_reg == ST_DONE) && (!rsp_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            if (op_reg == cdf_pkg::OP_QUERY)
            begin
                rsp_sink_reg <= sink_reg;
                rsp_y_reg    <= ny_reg;
                rsp_chg_reg  <= chg_reg;
            end
            else
            begin
                rsp_sink_reg <= '0;
                rsp_y_reg    <= '0;
                rsp_chg_reg  <= 1'b0;
            end
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.depth_sink = rsp_sink_reg;
    assign rsp.new_y      = rsp_y_reg;
    assign rsp.changed    = rsp_chg_reg;

endmodule

>>> rtl/cdf_checker.sv
// port-level checks of the crater depth field, bound to the top level
module cdf_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [cdf_pkg::DEPTH_W-1:0] rsp_sink,
    input logic [cdf_pkg::Y_W-1:0]     rsp_new_y,
    input logic                        rsp_changed
);
    logic [1:0] outst_reg;
    logic       req_acc;
    logic       rsp_acc;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    // items accepted and not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outst_reg <= '0;
        end
        else if (req_acc && !rsp_acc)
        begin
            outst_reg <= outst_reg + 1'b1;
        end
        else if (rsp_acc && !req_acc)
        begin
            outst_reg <= outst_reg - 1'b1;
        end
    end

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sink)
            && $stable(rsp_new_y) && $stable(rsp_changed))
        else $error("stalled result changed");

    // one item in work at a time
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> !req_ready)
        else $error("item accepted while another is in work");

    // no result without an item behind it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> outst_reg != 2'd0)
        else $error("result without accepted item");

    // at most one waiting result and one item in work
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        outst_reg != 2'd3)
        else $error("too many items outstanding");

endmodule

bind crater_depth_field_core cdf_checker u_cdf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_sink    (rsp.depth_sink),
    .rsp_new_y   (rsp.new_y),
    .rsp_changed (rsp.changed)
);

>>> tb/crater_sink_checker.sv
// crater depth field checker: watches channels, predicts sink and height, compares
module crater_sink_checker
    import cdf_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    cdf_req_if   req,
    cdf_rsp_if   rsp,
    cdf_cfg_if   cfg,
    output int   mismatches,
    output int   heights_waiting
);

    // one predicted result item
    typedef struct {
        logic [DEPTH_W-1:0]    sink;
        logic signed [Y_W-1:0] new_y;
        logic                  changed;
    } height_t;

    height_t heights_q[$];

    // predicted slot table and timing registers
    logic                      crater_on  [SLOTS];
    logic signed [COORD_W-1:0] crater_x   [SLOTS];
    logic signed [COORD_W-1:0] crater_z   [SLOTS];
    logic [RAD_W-1:0]          crater_rad [SLOTS];
    logic [DEPTH_W-1:0]        crater_dep [SLOTS];
    logic [TIME_W-1:0]         crater_age [SLOTS];
    logic [TIME_W-1:0]         punch_ms;
    logic [TIME_W-1:0]         heal_ms;

    // smoothstep on a q0.16 argument
    function automatic longint unsigned ease_q16(longint unsigned u);
        if (u == 0)
            return 0;
        if (u >= 65536)
            return 65536;
        return (u * u * (196608 - 2 * u)) >> 32;
    endfunction

    // integer square root, floor
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // sink of one crater at a query point, q12.8
    function automatic longint unsigned crater_sink_at(int k, int qx, int qz);
        longint unsigned age = crater_age[k];
        longint unsigned dep = crater_dep[k];
        longint unsigned pt  = punch_ms;
        longint unsigned ht  = heal_ms;
        longint unsigned now, u, d2, reach, ratio;
        longint          dx, dz;
        if (age < pt)
        begin
            u   = (age * 65536) / pt;
            now = (dep * ease_q16(u)) >> 16;
        end
        else if (ht == 0)
            now = 0;
        else
        begin
            u = ((age - pt) * 65536) / ht;
            if (u > 65536)
                u = 65536;
            now = (dep * (65536 - ease_q16(u))) >> 16;
        end
        if (now == 0 || crater_rad[k] == 0)
            return 0;
        dx    = longint'(qx) - longint'(crater_x[k]);
        dz    = longint'(qz) - longint'(crater_z[k]);
        d2    = longint'(dx * dx) + longint'(dz * dz);
        reach = root_floor(d2 << 16);
        ratio = (reach << 8) / crater_rad[k];
        if (ratio > 65536)
            ratio = 65536;
        return (now * (65536 - ease_q16(ratio))) >> 16;
    endfunction

    // apply one request item to the table and predict its result
    function automatic height_t predict_height();
        height_t         h;
        int              pick, ny, v;
        logic [TIME_W:0] life, aged;
        longint unsigned best, c;
        h.sink    = '0;
        h.new_y   = '0;
        h.changed = 1'b0;
        case (req.operation)
            OP_IMPACT:
            begin
                pick = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (pick < 0 && !crater_on[i])
                        pick = i;
                // table full: evict the oldest, lowest index on ties
                if (pick < 0)
                begin
                    pick = 0;
                    for (int i = 1; i < SLOTS; i++)
                        if (crater_age[i] > crater_age[pick])
                            pick = i;
                end
                crater_x[pick]   = req.pos_x;
                crater_z[pick]   = req.pos_z;
                crater_rad[pick] = req.radius;
                crater_dep[pick] = req.peak_depth;
                crater_age[pick] = '0;
                crater_on[pick]  = 1'b1;
            end
            OP_TICK:
            begin
                life = punch_ms + heal_ms;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (crater_on[i])
                    begin
                        aged = crater_age[i] + req.elapsed;
                        crater_age[i] = aged[TIME_W] ? '1 : aged[TIME_W-1:0];
                        if (crater_age[i] > life)
                            crater_on[i] = 1'b0;
                    end
                end
            end
            OP_QUERY:
            begin
                best = 0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (crater_on[i])
                    begin
                        c = crater_sink_at(i, req.pos_x, req.pos_z);
                        if (c > best)
                            best = c;
                    end
                end
                v  = int'(req.rest_y) * 256 - int'(best);
                ny = v / 256;
                if (ny < -32768)
                    ny = -32768;
                if (ny > 32767)
                    ny = 32767;
                h.sink    = best[DEPTH_W-1:0];
                h.new_y   = ny[Y_W-1:0];
                h.changed = (ny != int'(req.current_y));
            end
            default:
            begin
            end
        endcase
        return h;
    endfunction

    // track config writes, requests and results
    always @(posedge clk or negedge rst_n)
    begin : watch
        height_t want;
        if (!rst_n)
        begin
            heights_q.delete();
            punch_ms <= PUNCH_RST;
            heal_ms  <= HEAL_RST;
            for (int i = 0; i < SLOTS; i++)
            begin
                crater_on[i]  = 1'b0;
                crater_x[i]   = '0;
                crater_z[i]   = '0;
                crater_rad[i] = '0;
                crater_dep[i] = '0;
                crater_age[i] = '0;
            end
            mismatches      <= 0;
            heights_waiting <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_PUNCH)
                    punch_ms <= cfg.data;
                else if (cfg.index == CFG_HEAL)
                    heal_ms <= cfg.data;
            end
            if (rsp.valid && rsp.ready)
            begin
                if (heights_q.size() == 0)
                begin
                    $error("result item with nothing expected: sink %0d new_y %0d",
                           rsp.depth_sink, rsp.new_y);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = heights_q.pop_front();
                    if (rsp.depth_sink !== want.sink || rsp.new_y !== want.new_y ||
                        rsp.changed !== want.changed)
                        mismatches <= mismatches + 1;
                    if (rsp.depth_sink !== want.sink)
                        $error("sink: expected %0d, actual %0d", want.sink, rsp.depth_sink);
                    if (rsp.new_y !== want.new_y)
                        $error("new_y: expected %0d, actual %0d", want.new_y, rsp.new_y);
                    if (rsp.changed !== want.changed)
                        $error("changed: expected %0d, actual %0d", want.changed,
                               rsp.changed);
                end
            end
            if (req.valid && req.ready)
                heights_q.push_back(predict_height());
            heights_waiting <= heights_q.size();
        end
    end

endmodule

>>> tb/tb_top.sv
// testbench top of the crater depth field: stimulus, handshakes and verdict
module tb_top;
    import cdf_pkg::*;

    localparam int LIMIT = 3000000;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   heights_waiting;
    int   cycles = 0;
    bit   idling_on = 1'b1;
    bit   squeeze = 1'b0;

    // recent impact centers, so queries land inside craters
    int   hit_x[$];
    int   hit_z[$];

    cdf_req_if req ();
    cdf_rsp_if rsp ();
    cdf_cfg_if cfg ();

    crater_depth_field_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    crater_sink_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req),
        .rsp             (rsp),
        .cfg             (cfg),
        .mismatches      (mismatches),
        .heights_waiting (heights_waiting)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        rsp.ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (squeeze)
            begin
                rsp.ready <= 1'b0;
                repeat (2500) @(posedge clk);
                squeeze = 1'b0;
            end
            else if (idling_on && $urandom_range(0, 3) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                rsp.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    // offer one request item and wait until it is taken
    task automatic offer_request(logic [OP_W-1:0] op, int x, int z, int r, int d, int el,
                                 int ry, int cy);
        req.valid      <= 1'b1;
        req.operation  <= op;
        req.pos_x      <= x[COORD_W-1:0];
        req.pos_z      <= z[COORD_W-1:0];
        req.radius     <= r[RAD_W-1:0];
        req.peak_depth <= d[DEPTH_W-1:0];
        req.elapsed    <= el[TIME_W-1:0];
        req.rest_y     <= ry[Y_W-1:0];
        req.current_y  <= cy[Y_W-1:0];
        if (op == OP_IMPACT)
        begin
            hit_x.push_back(x);
            hit_z.push_back(z);
            if (hit_x.size() > 12)
            begin
                void'(hit_x.pop_front());
                void'(hit_z.pop_front());
            end
        end
        do
            @(posedge clk);
        while (!req.ready);
        if (idling_on && !squeeze && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    // write one timing register while the block is idle
    task automatic write_timing(logic [CFG_IDX_W-1:0] idx, int value);
        req.valid <= 1'b0;
        // let the count see an item taken at the last edge
        @(posedge clk);
        while (heights_waiting != 0)
            @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value[CFG_DAT_W-1:0];
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    // one random item, mostly queries close to recent impact centers
    task automatic random_item(int life);
        int pick, x, z, ry, cy, r, k;
        pick = $urandom_range(0, 99);
        ry   = $urandom_range(0, 65535) - 32768;
        if (pick < 25)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                x = $urandom_range(0, 65535) - 32768;
                z = $urandom_range(0, 65535) - 32768;
                r = $urandom_range(0, 65535);
            end
            else
            begin
                x = $urandom_range(0, 4000) - 2000;
                z = $urandom_range(0, 4000) - 2000;
                r = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 3000);
            end
            offer_request(OP_IMPACT, x, z, r, $urandom_range(0, 1048575), 0, ry, 0);
        end
        else if (pick < 45)
        begin
            r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                            : $urandom_range(0, life / 6 + 1);
            offer_request(OP_TICK, $urandom, $urandom, $urandom, $urandom, r, ry, $urandom);
        end
        else
        begin
            if (hit_x.size() != 0 && $urandom_range(0, 5) != 0)
            begin
                k = $urandom_range(0, hit_x.size() - 1);
                x = hit_x[k] + $urandom_range(0, 3000) - 1500;
                z = hit_z[k] + $urandom_range(0, 3000) - 1500;
            end
            else
            begin
                x = $urandom_range(0, 65535) - 32768;
                z = $urandom_range(0, 65535) - 32768;
            end
            case ($urandom_range(0, 3))
                0: cy = ry;
                1: cy = ry - $urandom_range(1, 40);
                default: cy = $urandom_range(0, 65535) - 32768;
            endcase
            offer_request(OP_QUERY, x, z, 0, 0, 0, ry, cy);
        end
    endtask

    // stimulus and verdict
    initial
    begin
        int punch_set[5];
        int heal_set[5];
        punch_set = '{150, 1, 65535, 30, 0};
        heal_set  = '{7500, 1, 65535, 400, 0};
        rst_n          <= 1'b0;
        req.valid      <= 1'b0;
        req.operation  <= OP_IMPACT;
        req.pos_x      <= '0;
        req.pos_z      <= '0;
        req.radius     <= '0;
        req.peak_depth <= '0;
        req.elapsed    <= '0;
        req.rest_y     <= '0;
        req.current_y  <= '0;
        cfg.valid      <= 1'b0;
        cfg.index      <= CFG_PUNCH;
        cfg.data       <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, flat craters, saturation, eviction
        offer_request(OP_QUERY, 0, 0, 0, 0, 0, 0, 0);
        offer_request(OP_IMPACT, -32768, 32767, 65535, 1048575, 0, 0, 0);
        offer_request(OP_IMPACT, 100, 100, 0, 500000, 0, 0, 0);
        offer_request(OP_IMPACT, -100, -100, 800, 0, 0, 0, 0);
        offer_request(OP_TICK, 0, 0, 0, 0, 75, 0, 0);
        offer_request(OP_QUERY, -32768, 32767, 0, 0, 0, -32768, -32768);
        offer_request(OP_QUERY, 32767, -32768, 0, 0, 0, 32767, 32767);
        offer_request(OP_QUERY, 100, 100, 0, 0, 0, 5, 4);
        offer_request(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
        offer_request(OP_TICK, 0, 0, 0, 0, 1000, 0, 0);
        offer_request(OP_QUERY, -32000, 32000, 0, 0, 0, -32768, 0);
        for (int i = 0; i < 9; i++)
            offer_request(OP_IMPACT, i * 300, -i * 200, 1000 + i * 100, 1048575 - i,
                          0, 0, 0);
        offer_request(OP_TICK, 0, 0, 0, 0, 65535, 0, 0);
        offer_request(OP_QUERY, 300, -200, 0, 0, 0, 0, 0);

        // phases over several timing settings, the last phase drops idling after 60 items
        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph == 4)
            begin
                punch_set[ph] = $urandom_range(1, 2000);
                heal_set[ph]  = $urandom_range(1, 20000);
            end
            write_timing(CFG_PUNCH, punch_set[ph]);
            write_timing(CFG_HEAL, heal_set[ph]);
            if (ph == 3)
                squeeze = 1'b1;
            for (int n = 0; n < 125; n++)
            begin
                if (ph == 4 && n == 60)
                    idling_on = 1'b0;
                random_item(punch_set[ph] + heal_set[ph]);
            end
        end
        req.valid <= 1'b0;

        while (heights_waiting != 0)
            @(posedge clk);
        repeat (1000) @(posedge clk);
        if (mismatches == 0 && heights_waiting == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
